### src/lbod_pkg.sv
// Shared types, constants and character classification for the line break detector.
// Depends on nothing; every other file imports it.
package lbod_pkg;

    localparam int LBOD_QUEUE_DEPTH = 2;

    localparam logic [15:0] IDEO_SPACE  = 16'h3000;
    localparam logic [15:0] NUMERO_SIGN = 16'h2116;

    typedef struct packed {
        logic [15:0] char_code;
        logic        section_start;
    } lbod_in_t;

    typedef struct packed {
        logic break_before;
        logic bracket_open;
    } lbod_out_t;

    typedef struct packed {
        logic latin;
        logic digit;
        logic cjk;
        logic punct;
        logic connect;
        logic opener;
        logic prefix;
        logic space;
    } lbod_cls_t;

    // word handed from the front end to the back end through the queue
    typedef struct packed {
        lbod_cls_t cls;
        logic      section_start;
    } lbod_item_t;

    function automatic logic is_latin(input logic [15:0] c);
        return c inside {[16'h0041:16'h005A], [16'h0061:16'h007A],
                         [16'h00C0:16'h024F], [16'h1E00:16'h1EFF],
                         [16'h2C60:16'h2C7F], [16'hA720:16'hA7FF],
                         [16'hFF21:16'hFF3A], [16'hFF41:16'hFF5A]};
    endfunction

    function automatic logic is_digit(input logic [15:0] c);
        return c inside {[16'h0030:16'h0039]};
    endfunction

    function automatic logic is_cjk(input logic [15:0] c);
        return c inside {[16'h1100:16'h11FF], [16'h2E80:16'h2FFF],
                         [16'h3040:16'h9FBF], [16'hAC00:16'hD7AF],
                         [16'hF900:16'hFAFF], [16'hFE30:16'hFE4F],
                         16'h3005, 16'h3006, [16'h3021:16'h3029],
                         [16'h3031:16'h3035], [16'hFF66:16'hFF9D]};
    endfunction

    function automatic logic is_punct(input logic [15:0] c);
        return c inside {16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0021,
                         16'h0022, [16'h0027:16'h0029], [16'h002C:16'h002F],
                         16'h003A, 16'h003B, 16'h003F, 16'h005B, 16'h005D,
                         16'h007B, 16'h007D,
                         16'h0082, 16'h0084, 16'h0085, [16'h0091:16'h0094],
                         16'h0096, 16'h00B4, 16'h00B8,
                         [16'h2010:16'h2013], [16'h2018:16'h201F],
                         [16'h2032:16'h2037], [16'h203C:16'h203E], 16'h2044,
                         [16'h3001:16'h3003], 16'h3005, [16'h3009:16'h3011],
                         [16'h3014:16'h301B], [16'h301D:16'h301F],
                         [16'hFE50:16'hFE5E], 16'hFE63,
                         16'hFF01, 16'hFF02, [16'hFF07:16'hFF09], 16'hFF0C,
                         16'hFF0E, 16'hFF0F, 16'hFF1A, 16'hFF1B, 16'hFF1F,
                         16'hFF3B, 16'hFF3D, 16'hFF40, [16'hFF5B:16'hFF5D],
                         [16'hFF61:16'hFF65], 16'hFF9E, 16'hFF9F};
    endfunction

    function automatic logic is_connect(input logic [15:0] c);
        return c inside {16'h0006, 16'h0027, [16'h002C:16'h002F]};
    endfunction

    function automatic logic is_opener(input logic [15:0] c);
        return c inside {16'h0001, 16'h0003, 16'h0028, 16'h005B, 16'h007B,
                         16'h300A, 16'h300C, 16'h300E, 16'h3010, 16'h3014,
                         16'h3016, 16'h3018, 16'h301A, 16'hFF08, 16'hFF3B,
                         16'hFF5B, 16'hFF62};
    endfunction

    function automatic logic is_prefix(input logic [15:0] c);
        return c inside {16'h0024, 16'h0080, [16'h00A2:16'h00A5],
                         [16'h20A0:16'h20CF], 16'hFE69, 16'hFF04, 16'hFFE0,
                         16'hFFE1, 16'hFFE5, 16'hFFE6, NUMERO_SIGN};
    endfunction

    function automatic lbod_cls_t classify(input logic [15:0] c);
        lbod_cls_t k;
        k.latin   = is_latin(c);
        k.digit   = is_digit(c);
        k.cjk     = is_cjk(c);
        k.punct   = is_punct(c);
        k.connect = is_connect(c);
        k.opener  = is_opener(c);
        k.prefix  = is_prefix(c);
        k.space   = (c == 16'h0020) || (c == IDEO_SPACE);
        return k;
    endfunction

    // wrap point between predecessor p and current c, by class only
    function automatic logic divides(input lbod_cls_t p, input lbod_cls_t c);
        logic r;
        if ((p.latin || p.digit) && (c.latin || c.digit)) begin
            r = 1'b0;
        end else if (c.space || c.punct) begin
            r = 1'b0;
        end else if (p.connect || c.connect) begin
            r = 1'b0;
        end else if (p.space || p.punct) begin
            r = 1'b1;
        end else if (p.prefix) begin
            r = 1'b0;
        end else if (c.prefix || c.cjk) begin
            r = 1'b1;
        end else begin
            r = p.cjk;
        end
        return r;
    endfunction

endpackage

### src/line_break_opportunity_detector_unit.sv
// Top level of the line break opportunity detector: front end, queue, back end.
// Depends on lbod_pkg, lbod_front, lbod_queue and lbod_back.
//
//  channel | direction | handshake          | word
//  s_      | in        | s_valid / s_ready  | lbod_in_t  (char_code, section_start)
//  m_      | out       | m_valid / m_ready  | lbod_out_t (break_before, bracket_open)
//
// One word in and one word out per cycle sustained while m_ready holds; each word
// passes the front register, a queue slot and the result register in that order.
// The back end's history loop (previous classes, opened flag) sets the rate.
// aresetn is synchronous: it empties all stages and clears the history.
// A stalled m_ fills the queue first; s_ready drops only once it is full.
module line_break_opportunity_detector_unit #(
    parameter int QUEUE_DEPTH = lbod_pkg::LBOD_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lbod_pkg::lbod_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lbod_pkg::lbod_out_t m_data
);
    import lbod_pkg::*;

    logic       push_valid;
    logic       push_ready;
    lbod_item_t push_item;
    logic       pop_valid;
    logic       pop_ready;
    lbod_item_t pop_item;

    lbod_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lbod_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_item  (pop_item)
    );

    lbod_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### src/lbod_front.sv
// Front end: takes input words and registers their character classes.
// Depends on lbod_pkg.
module lbod_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lbod_pkg::lbod_in_t  s_data,
    output logic                push_valid,
    input  logic                push_ready,
    output lbod_pkg::lbod_item_t push_item
);
    import lbod_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    lbod_item_t item_reg;

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.cls           <= classify(s_data.char_code);
            item_reg.section_start <= s_data.section_start;
        end
    end

endmodule

### src/lbod_queue.sv
// Short first-in first-out queue of classified words between front and back end.
// Depends on lbod_pkg.
module lbod_queue #(
    parameter int DEPTH = lbod_pkg::LBOD_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  lbod_pkg::lbod_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output lbod_pkg::lbod_item_t rd_item
);
    import lbod_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lbod_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### src/lbod_back.sv
// Back end: applies the history (previous classes, opened flag) and drives the result word.
// Depends on lbod_pkg.
module lbod_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  lbod_pkg::lbod_item_t pop_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lbod_pkg::lbod_out_t  m_data
);
    import lbod_pkg::*;

    lbod_cls_t prev_reg;
    logic      opened_reg;
    logic      opened_next;
    logic      valid_reg;
    logic      valid_next;
    lbod_out_t data_reg;
    lbod_out_t data_next;
    lbod_cls_t pred;
    logic      opened_in;
    logic      take;

    assign pop_ready = !valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;
    assign m_valid   = valid_reg;
    assign m_data    = data_reg;

    always_comb begin
        // section start: the word is its own predecessor and the flag is dropped
        pred      = pop_item.section_start ? pop_item.cls : prev_reg;
        opened_in = pop_item.section_start ? 1'b0 : opened_reg;

        opened_next            = opened_in;
        data_next.break_before = 1'b0;
        if (!opened_in) begin
            if (pop_item.cls.opener) begin
                opened_next            = 1'b1;
                data_next.break_before = 1'b1;
            end else begin
                data_next.break_before = divides(pred, pop_item.cls);
            end
        end else if (!pop_item.cls.space && !pop_item.cls.opener) begin
            opened_next = 1'b0;
        end
        data_next.bracket_open = opened_next;

        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // reset predecessor is code 0, which has no class
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= '0;
            opened_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                prev_reg   <= pop_item.cls;
                opened_reg <= opened_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= data_next;
        end
    end

endmodule

### src/lbod_checker.sv
// Port-level checks on the detector's top level, attached by bind.
// Depends on lbod_pkg and line_break_opportunity_detector_unit.
module lbod_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input lbod_pkg::lbod_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input lbod_pkg::lbod_out_t m_data
);
    import lbod_pkg::*;

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       last_open_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (s_fire && !m_fire) begin
            pending_next = pending_reg + 1'b1;
        end else if (m_fire && !s_fire) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= '0;
            last_open_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            if (m_fire) begin
                last_open_reg <= m_data.bracket_open;
            end
        end
    end

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 4'd0)
        else $error("result word without an accepted input word");

    // a held bracket without a break can only continue an open bracket
    a_open_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && m_data.bracket_open && !m_data.break_before |-> last_open_reg)
        else $error("bracket held open without an opener");

endmodule

bind line_break_opportunity_detector_unit lbod_checker u_lbod_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
